### src/ter_pkg.sv
// Shared types and constants for the triangle edge rasterizer.
// No dependencies.
package ter_pkg;
   localparam int DIM_BITS_DEF  = 12;
   localparam int FRAC_BITS_DEF = 4;
   localparam int SIZE_W  = 13;
   localparam int COLOR_W = 24;
   localparam int WORD_W  = 24;
   localparam int VCOORD_W = 16;
   localparam int CHAN_W  = 8;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FORMAT = 2'd2
   } csr_idx_type;
endpackage

### src/ter_front.sv
// Front end: scales vertices and packs color into registers; the back end computes the bounding box.
// Depends on ter_pkg.
module ter_front #(
   parameter int DIM_BITS  = ter_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = ter_pkg::FRAC_BITS_DEF,
   localparam int CW = DIM_BITS + FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_mode,
   input  logic [ter_pkg::VCOORD_W-1:0] vx [3],
   input  logic [ter_pkg::VCOORD_W-1:0] vy [3],
   input  logic [ter_pkg::CHAN_W-1:0]   red,
   input  logic [ter_pkg::CHAN_W-1:0]   green,
   input  logic [ter_pkg::CHAN_W-1:0]   blue,
   input  logic [ter_pkg::SIZE_W-1:0]   width,
   input  logic [ter_pkg::SIZE_W-1:0]   height,
   input  logic                         fmt,
   output logic                         out_valid,
   output logic                         out_mode,
   output logic [CW-1:0]                cx [3],
   output logic [CW-1:0]                cy [3],
   output logic [ter_pkg::COLOR_W-1:0]  color
);
   import ter_pkg::*;
   localparam int PW = VCOORD_W + SIZE_W;
   localparam int SH = 16 - FRAC_BITS;
   localparam logic [PW-1:0] CMAX = PW'((64'd1 << CW) - 64'd1);

   logic            valid_ff;
   logic            mode_ff;
   logic [CW-1:0]   cx_ff [3];
   logic [CW-1:0]   cy_ff [3];
   logic [COLOR_W-1:0] color_ff;

   function automatic logic [CW-1:0] scale(input logic [VCOORD_W-1:0] f,
                                           input logic [SIZE_W-1:0] s);
      logic [PW-1:0] p;
      p = (PW'(f) * PW'(s)) >> SH;
      return (p > CMAX) ? CMAX[CW-1:0] : p[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      mode_ff <= in_mode;
      for (int i = 0; i < 3; i++) begin
         cx_ff[i] <= scale(vx[i], width);
         cy_ff[i] <= scale(vy[i], height);
      end
      color_ff <= fmt ? {red, green, blue} : {blue, green, red};
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign cx = cx_ff;
   assign cy = cy_ff;
   assign color = color_ff;
endmodule

### src/ter_back.sv
// Back end: holds the triangle, scans the box and evaluates edge functions.
// Depends on ter_pkg.
module ter_back #(
   parameter int DIM_BITS  = ter_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = ter_pkg::FRAC_BITS_DEF,
   localparam int CW = DIM_BITS + FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_mode,
   input  logic [CW-1:0]               cx [3],
   input  logic [CW-1:0]               cy [3],
   input  logic [ter_pkg::COLOR_W-1:0] color,
   output logic                        in_take,
   input  logic [ter_pkg::SIZE_W-1:0]  width,
   input  logic [ter_pkg::SIZE_W-1:0]  height,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [11:0]                 rsp_pixel_x,
   output logic [11:0]                 rsp_pixel_y,
   output logic [ter_pkg::WORD_W-1:0]  rsp_word_index,
   output logic [ter_pkg::COLOR_W-1:0] rsp_color_word,
   output logic                        rsp_write_enable,
   output logic                        rsp_last
);
   import ter_pkg::*;
   localparam int DW = CW + 1;
   localparam int EW = 2 * DW + 1;
   localparam logic [CW:0] ONE = (CW+1)'(1) << FRAC_BITS;
   localparam logic signed [EW-1:0] LIM = -(EW'(1) << (2 * FRAC_BITS));

   logic [CW-1:0] vx_ff [3], vy_ff [3];
   logic [COLOR_W-1:0] col_ff;
   logic [CW-1:0] minx_ff, maxx_ff, maxy_ff, sx_ff, sy_ff;
   logic active_ff;

   // stage 1 (products)
   logic s1_ff;
   logic signed [EW-1:0] pa_ff [3], pb_ff [3];
   logic [DIM_BITS-1:0] p1x_ff, p1y_ff;
   logic [COLOR_W-1:0] c1_ff;
   logic l1_ff;
   // output register
   logic o_ff;
   logic [11:0] ox_ff, oy_ff;
   logic [WORD_W-1:0] ow_ff;
   logic [COLOR_W-1:0] oc_ff;
   logic owe_ff, ol_ff;

   logic adv;
   logic [CW-1:0] mnx, mxx, mny, mxy;
   logic [CW:0] nx, ny;
   logic last_w;

   assign adv = !(o_ff && rsp_stall);
   assign in_take = in_valid && adv;

   always_comb begin
      mnx = cx[0]; mxx = cx[0]; mny = cy[0]; mxy = cy[0];
      for (int i = 1; i < 3; i++) begin
         if (cx[i] < mnx) mnx = cx[i];
         if (cx[i] > mxx) mxx = cx[i];
         if (cy[i] < mny) mny = cy[i];
         if (cy[i] > mxy) mxy = cy[i];
      end
      nx = {1'b0, sx_ff} + ONE;
      ny = {1'b0, sy_ff} + ONE;
      last_w = !(nx < {1'b0, maxx_ff}) && !(ny < {1'b0, maxy_ff});
   end

   function automatic logic signed [DW-1:0] df(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0; s1_ff <= 1'b0; o_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin vx_ff[i] <= '0; vy_ff[i] <= '0; end
         col_ff <= '0; minx_ff <= '0; maxx_ff <= '0; maxy_ff <= '0;
         sx_ff <= '0; sy_ff <= '0;
      end else if (adv) begin
         s1_ff <= 1'b0;
         if (in_valid && !in_mode) begin
            vx_ff <= cx; vy_ff <= cy; col_ff <= color;
            minx_ff <= mnx; maxx_ff <= mxx; maxy_ff <= mxy;
            sx_ff <= mnx; sy_ff <= mny;
            active_ff <= (mnx < mxx) && (mny < mxy);
         end else if (in_valid && active_ff) begin
            s1_ff <= 1'b1;
            for (int i = 0; i < 3; i++) begin
               pa_ff[i] <= EW'(df(sx_ff, vx_ff[i]))
                         * EW'(df(vy_ff[(i+1)%3], vy_ff[i]));
               pb_ff[i] <= EW'(df(sy_ff, vy_ff[i]))
                         * EW'(df(vx_ff[(i+1)%3], vx_ff[i]));
            end
            p1x_ff <= sx_ff[CW-1:FRAC_BITS];
            p1y_ff <= sy_ff[CW-1:FRAC_BITS];
            c1_ff <= col_ff;
            l1_ff <= last_w;
            if (nx < {1'b0, maxx_ff}) sx_ff <= nx[CW-1:0];
            else begin
               sx_ff <= minx_ff;
               if (ny < {1'b0, maxy_ff}) sy_ff <= ny[CW-1:0];
               else active_ff <= 1'b0;
            end
         end
         o_ff <= s1_ff;
         if (s1_ff) begin
            ox_ff <= 12'(p1x_ff);
            oy_ff <= 12'(p1y_ff);
            ow_ff <= WORD_W'(p1y_ff * width + 37'(p1x_ff));
            oc_ff <= c1_ff;
            owe_ff <= (pa_ff[0] - pb_ff[0] > LIM) && (pa_ff[1] - pb_ff[1] > LIM)
                   && (pa_ff[2] - pb_ff[2] > LIM)
                   && (SIZE_W'(p1x_ff) < width) && (SIZE_W'(p1y_ff) < height);
            ol_ff <= l1_ff;
         end
      end
   end

   assign rsp_valid = o_ff;
   assign rsp_pixel_x = ox_ff;
   assign rsp_pixel_y = oy_ff;
   assign rsp_word_index = ow_ff;
   assign rsp_color_word = oc_ff;
   assign rsp_write_enable = owe_ff;
   assign rsp_last = ol_ff;
endmodule

### src/triangle_edge_rasterizer.sv
// Top level of the edge-function triangle rasterizer.
// Uses ter_pkg, ter_front, ter_back.
//
// Usage: req_ carries words; mode 0 loads a triangle (no response), mode 1
// steps one sample of the bounding box and yields one rsp_ word while a
// triangle is active. csr_ writes screen_width (0), screen_height (1) and
// the color order (2); csr_ready is always high.
// Throughput: one word per cycle while rsp_ is not stalled. A word passes the
// front scaling register, a queue entry, the edge product register and the
// output register on its way from req_ to rsp_.
// A stall on rsp_ freezes the back end; the front register and a four-entry
// queue absorb words already in flight, and req_stall rises once the queue
// can no longer take them.
// Reset: registers return to 640x480 with color packed {blue, green, red}, no triangle loaded, queue empty.
module triangle_edge_rasterizer #(
   parameter int DIM_BITS  = ter_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = ter_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_vert0_x,
   input  logic [15:0] req_vert0_y,
   input  logic [15:0] req_vert1_x,
   input  logic [15:0] req_vert1_y,
   input  logic [15:0] req_vert2_x,
   input  logic [15:0] req_vert2_y,
   input  logic [7:0]  req_color_red,
   input  logic [7:0]  req_color_green,
   input  logic [7:0]  req_color_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [23:0] rsp_word_index,
   output logic [23:0] rsp_color_word,
   output logic        rsp_write_enable,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import ter_pkg::*;
   localparam int CW = DIM_BITS + FRAC_BITS;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic fmt_ff;
   logic [VCOORD_W-1:0] vx [3], vy [3];
   logic f_valid, f_mode, take;
   logic [CW-1:0] f_cx [3], f_cy [3];
   logic [COLOR_W-1:0] f_color;

   // queue between front and back
   logic q_mode_ff [QDEPTH];
   logic [CW-1:0] q_cx_ff [QDEPTH][3], q_cy_ff [QDEPTH][3];
   logic [COLOR_W-1:0] q_col_ff [QDEPTH];
   logic [QCNT_W-1:0] q_cnt_ff;
   logic [QPTR_W-1:0] q_rd_ff, q_wr_ff;
   logic q_push, q_pop, q_empty;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd640; height_ff <= 13'd480; fmt_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_WIDTH:  width_ff <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_FORMAT: fmt_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign vx = '{req_vert0_x, req_vert1_x, req_vert2_x};
   assign vy = '{req_vert0_y, req_vert1_y, req_vert2_y};
   // front word plus queue may hold at most QDEPTH words
   assign req_stall = (q_cnt_ff + QCNT_W'(f_valid)) >= QCNT_W'(QDEPTH);

   ter_front #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid && !req_stall), .in_mode(req_mode),
      .vx, .vy, .red(req_color_red), .green(req_color_green),
      .blue(req_color_blue), .width(width_ff), .height(height_ff), .fmt(fmt_ff),
      .out_valid(f_valid), .out_mode(f_mode), .cx(f_cx), .cy(f_cy),
      .color(f_color));

   assign q_empty = (q_cnt_ff == '0);
   assign q_push = f_valid;
   assign q_pop = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0; q_rd_ff <= '0; q_wr_ff <= '0;
      end else begin
         q_cnt_ff <= q_cnt_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
         if (q_push) q_wr_ff <= q_wr_ff + 1'b1;
         if (q_pop) q_rd_ff <= q_rd_ff + 1'b1;
      end
      if (q_push) begin
         q_mode_ff[q_wr_ff] <= f_mode;
         q_cx_ff[q_wr_ff] <= f_cx;
         q_cy_ff[q_wr_ff] <= f_cy;
         q_col_ff[q_wr_ff] <= f_color;
      end
   end

   ter_back #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(!q_empty), .in_mode(q_mode_ff[q_rd_ff]),
      .cx(q_cx_ff[q_rd_ff]), .cy(q_cy_ff[q_rd_ff]), .color(q_col_ff[q_rd_ff]),
      .in_take(take), .width(width_ff), .height(height_ff),
      .rsp_valid, .rsp_stall, .rsp_pixel_x, .rsp_pixel_y, .rsp_word_index,
      .rsp_color_word, .rsp_write_enable, .rsp_last);

   a_qbound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue overflow");
   a_nopop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !take) else $error("pop from empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (q_cnt_ff == QCNT_W'(QDEPTH)) |-> !f_valid || take)
      else $error("push into full queue");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      (q_cnt_ff == QCNT_W'(QDEPTH)) |-> req_stall) else $error("accept while queue full");
endmodule

### tb/testbench.sv
// Self-checking testbench for triangle_edge_rasterizer: drives triangle loads and
// sample steps, predicts each rasterized sample and compares it field by field.
// Depends on ter_pkg and the triangle_edge_rasterizer RTL.
`timescale 1ns / 1ps
module testbench;
   import ter_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int CB = DIM_BITS_DEF + FRAC_BITS_DEF;
   localparam logic [31:0] CMAX = (32'd1 << CB) - 1;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [11:0] px;
      logic [11:0] py;
      logic [23:0] widx;
      logic [23:0] color;
      logic        we;
      logic        last;
   } sample_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_mode = 0;
   logic [15:0] req_vert0_x = 0, req_vert0_y = 0, req_vert1_x = 0;
   logic [15:0] req_vert1_y = 0, req_vert2_x = 0, req_vert2_y = 0;
   logic [7:0] req_color_red = 0, req_color_green = 0, req_color_blue = 0;
   logic rsp_stall = 0, csr_valid = 0;
   logic [1:0] csr_index = 0;
   logic [12:0] csr_data = 0;
   wire req_stall, rsp_valid, rsp_write_enable, rsp_last, csr_ready;
   wire [11:0] rsp_pixel_x, rsp_pixel_y;
   wire [23:0] rsp_word_index, rsp_color_word;

   triangle_edge_rasterizer i_dut (.*);

   always #6 clock = ~clock;

   // predictor state
   int unsigned scr_w = 640, scr_h = 480, fmt = 0;
   longint vc[6];
   int unsigned pcolor, bminx, bmaxx, bmaxy, sx, sy;
   bit tri_active;
   sample_type expected_samples[$];
   int errors = 0, cycles = 0;
   bit stall_mode = 0;

   function automatic int unsigned scale(logic [15:0] f, int unsigned sz);
      longint unsigned p;
      p = (longint'(f) * sz) >> (16 - FB);
      return (p > CMAX) ? CMAX : 32'(p);
   endfunction

   function automatic longint edge_fn(longint x, longint y, int a, int b);
      return (x - vc[2*a]) * (vc[2*b+1] - vc[2*a+1])
           - (y - vc[2*a+1]) * (vc[2*b] - vc[2*a]);
   endfunction

   function automatic void predict(logic m, logic [15:0] v[6], logic [7:0] r,
                                   logic [7:0] g, logic [7:0] b);
      sample_type s;
      longint lim;
      int unsigned miny, nx, ny, pxi, pyi;
      bit ins, last;
      if (m == 0) begin
         for (int i = 0; i < 6; i++) vc[i] = scale(v[i], (i % 2) ? scr_h : scr_w);
         pcolor = fmt ? 32'({r, g, b}) : 32'({b, g, r});
         bminx = 32'(vc[0]); bmaxx = 32'(vc[0]); miny = 32'(vc[1]); bmaxy = 32'(vc[1]);
         for (int i = 1; i < 3; i++) begin
            if (vc[2*i] < bminx) bminx = 32'(vc[2*i]);
            if (vc[2*i] > bmaxx) bmaxx = 32'(vc[2*i]);
            if (vc[2*i+1] < miny) miny = 32'(vc[2*i+1]);
            if (vc[2*i+1] > bmaxy) bmaxy = 32'(vc[2*i+1]);
         end
         sx = bminx; sy = miny;
         tri_active = (bminx < bmaxx) && (miny < bmaxy);
         return;
      end
      if (!tri_active) return;
      lim = -(64'sd1 << (2 * FB));
      ins = edge_fn(sx, sy, 0, 1) > lim && edge_fn(sx, sy, 1, 2) > lim
         && edge_fn(sx, sy, 2, 0) > lim;
      pxi = sx >> FB; pyi = sy >> FB;
      s.px = 12'(pxi); s.py = 12'(pyi);
      s.widx = 24'(longint'(pyi) * scr_w + pxi);
      s.color = 24'(pcolor);
      s.we = ins && pxi < scr_w && pyi < scr_h;
      last = 0;
      nx = sx + (1 << FB);
      if (nx < bmaxx) sx = nx;
      else begin
         ny = sy + (1 << FB);
         sx = bminx;
         if (ny < bmaxy) sy = ny;
         else begin last = 1; tri_active = 0; end
      end
      s.last = last;
      expected_samples.push_back(s);
   endfunction

   // bursty sender
   int burst_left = 0;
   task automatic send_word(logic m, logic [15:0] v[6], logic [7:0] r,
                            logic [7:0] g, logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1; req_mode <= m;
      req_vert0_x <= v[0]; req_vert0_y <= v[1]; req_vert1_x <= v[2];
      req_vert1_y <= v[3]; req_vert2_x <= v[4]; req_vert2_y <= v[5];
      req_color_red <= r; req_color_green <= g; req_color_blue <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict(m, v, r, g, b);
   endtask

   task automatic idle_sender();
      req_valid <= 0;
      burst_left = 0;
      @(posedge clock);
   endtask

   task automatic drain();
      idle_sender();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int unsigned val);
      csr_valid <= 1; csr_index <= idx; csr_data <= 13'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
      case (idx)
         CSR_WIDTH:  scr_w = val;
         CSR_HEIGHT: scr_h = val;
         default:    fmt = val & 1;
      endcase
   endtask

   task automatic send_tri(logic [15:0] v[6], logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
      send_word(1'b0, v, r, g, b);
   endtask

   task automatic send_step();
      logic [15:0] v[6];
      foreach (v[i]) v[i] = 16'($urandom);
      send_word(1'b1, v, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_directed();
      logic [15:0] v[6];
      // step before any triangle
      send_step();
      v = '{16'h1000, 16'h1000, 16'h1400, 16'h1000, 16'h1000, 16'h1400};
      send_tri(v, 8'hff, 8'h00, 8'h80);
      repeat (10) send_step();
      // opposite winding
      v = '{16'h1000, 16'h1000, 16'h1000, 16'h1400, 16'h1400, 16'h1000};
      send_tri(v, 8'h12, 8'h34, 8'h56);
      repeat (6) send_step();
      // reload mid-scan, degenerate box
      v = '{16'hffff, 16'h0, 16'hffff, 16'hffff, 16'hffff, 16'h8000};
      send_tri(v, 8'h00, 8'hff, 8'h00);
      send_step();
      v = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
      send_tri(v, 8'h00, 8'h00, 8'h00);
      send_step();
      drain();
   endtask

   task automatic run_random(int n_items, int max_span);
      logic [15:0] v[6];
      int base;
      for (int k = 0; k < n_items; ) begin
         base = $urandom;
         if ($urandom_range(0, 9) == 0) foreach (v[i]) v[i] = 16'($urandom);
         else foreach (v[i]) v[i] = 16'(base + $urandom_range(0, max_span) -
                                         max_span / 2);
         send_tri(v, 8'($urandom), 8'($urandom), 8'($urandom)); k++;
         repeat ($urandom_range(0, 40)) begin send_step(); k++; end
         if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
   endtask

   task automatic test_settings();
      logic [15:0] v[6];
      write_csr(CSR_FORMAT, 1);
      run_random(300, 1200);
      write_csr(CSR_WIDTH, 4096); write_csr(CSR_HEIGHT, 4096);
      run_random(300, 100);
      write_csr(CSR_WIDTH, 8191); write_csr(CSR_HEIGHT, 8191);
      write_csr(CSR_FORMAT, 0);
      v = '{16'hfff0, 16'hfff0, 16'hffff, 16'hfff8, 16'hfff8, 16'hffff};
      send_tri(v, 8'd1, 8'd2, 8'd3);
      repeat (5) send_step();
      drain();
      write_csr(CSR_WIDTH, 1); write_csr(CSR_HEIGHT, 1);
      run_random(150, 65535);
      write_csr(CSR_WIDTH, 37); write_csr(CSR_HEIGHT, 23);
      run_random(300, 20000);
      // change screen after load: off-screen suppression
      v = '{16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'hffff};
      send_tri(v, 8'd9, 8'd8, 8'd7);
      drain();
      write_csr(CSR_WIDTH, 0); write_csr(CSR_HEIGHT, 5);
      repeat (20) send_step();
      drain();
      write_csr(CSR_WIDTH, 640); write_csr(CSR_HEIGHT, 480);
      write_csr(CSR_FORMAT, 1);
      run_random(750, 3000);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_settings();
      if (errors == 0) $display("PASS triangle_edge_rasterizer");
      else $display("FAIL triangle_edge_rasterizer");
      $finish;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2) != 0;
      rsp_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
      if (cycles > LIMIT) begin
         $display("FAIL triangle_edge_rasterizer");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      sample_type e, a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a = '{rsp_pixel_x, rsp_pixel_y, rsp_word_index, rsp_color_word,
               rsp_write_enable, rsp_last};
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t unexpected word %h", $time, a);
         end else begin
            e = expected_samples.pop_front();
            if (a != e) begin
               errors++;
               $display("%0t mismatch exp x%0d y%0d w%h c%h we%b l%b",
                        $time, e.px, e.py, e.widx, e.color, e.we, e.last);
               $display("%0t          act x%0d y%0d w%h c%h we%b l%b",
                        $time, a.px, a.py, a.widx, a.color, a.we, a.last);
            end
         end
      end
   end
endmodule

### filelist.f
src/ter_pkg.sv
src/ter_front.sv
src/ter_back.sv
src/triangle_edge_rasterizer.sv
tb/testbench.sv
